[src/wcdc_pkg.sv]
// ----------------------------------------------------------------------------
// wcdc_pkg
// shared types and constants of the waste container door controller
// ----------------------------------------------------------------------------
package wcdc_pkg;

    localparam int CFG_WIDTH  = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // register indexes
    localparam logic [1:0] REG_PERIOD_TICKS  = 2'd0;
    localparam logic [1:0] REG_IDLE_LIMIT    = 2'd1;
    localparam logic [1:0] REG_OPEN_LIMIT    = 2'd2;
    localparam logic [1:0] REG_CLOSING_LIMIT = 2'd3;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] RST_PERIOD_TICKS  = 16'd1;
    localparam logic [CFG_WIDTH-1:0] RST_IDLE_LIMIT    = 16'd100;
    localparam logic [CFG_WIDTH-1:0] RST_OPEN_LIMIT    = 16'd100;
    localparam logic [CFG_WIDTH-1:0] RST_CLOSING_LIMIT = 16'd20;

    typedef enum logic [2:0] {
        MODE_ACCEPT      = 3'd0,
        MODE_OPEN        = 3'd1,
        MODE_CLOSING     = 3'd2,
        MODE_IDLE_SLEEP  = 3'd3,
        MODE_HOT         = 3'd4,
        MODE_FULL        = 3'd5,
        MODE_FAULT_SLEEP = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        MSG_PRESS_OPEN  = 3'd0,
        MSG_PRESS_CLOSE = 3'd1,
        MSG_RECEIVED    = 3'd2,
        MSG_PROBLEM     = 3'd3,
        MSG_FULL        = 3'd4,
        MSG_SCREEN_OFF  = 3'd5
    } msg_t;

    // lamp_state bits: [0] green, [1] red
    localparam logic [1:0] LAMP_GREEN = 2'b01;
    localparam logic [1:0] LAMP_RED   = 2'b10;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] period_ticks;
        logic [CFG_WIDTH-1:0] idle_limit;
        logic [CFG_WIDTH-1:0] open_limit;
        logic [CFG_WIDTH-1:0] closing_limit;
    } cfg_t;

    typedef struct packed {
        logic temp_high;
        logic level_full;
        logic open_press;
        logic close_press;
        logic user_present;
    } sense_t;

    typedef struct packed {
        logic [2:0] mode_code;
        logic       door_open;
        logic       green_on;
        logic       red_on;
        logic [2:0] message_code;
    } result_t;

    function automatic msg_t mode_message(mode_t m);
        msg_t msg;
        case (m)
            MODE_ACCEPT:  msg = MSG_PRESS_OPEN;
            MODE_OPEN:    msg = MSG_PRESS_CLOSE;
            MODE_CLOSING: msg = MSG_RECEIVED;
            MODE_HOT:     msg = MSG_PROBLEM;
            MODE_FULL:    msg = MSG_FULL;
            default:      msg = MSG_SCREEN_OFF;
        endcase
        return msg;
    endfunction

endpackage

[src/wcdc_apb_regs.sv]
// ----------------------------------------------------------------------------
// wcdc_apb_regs
// apb configuration registers: period length and the three timeout limits
// ----------------------------------------------------------------------------
module wcdc_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wcdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wcdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wcdc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output wcdc_pkg::cfg_t                   cfg
);

    wcdc_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks  <= wcdc_pkg::RST_PERIOD_TICKS;
            cfg_reg.idle_limit    <= wcdc_pkg::RST_IDLE_LIMIT;
            cfg_reg.open_limit    <= wcdc_pkg::RST_OPEN_LIMIT;
            cfg_reg.closing_limit <= wcdc_pkg::RST_CLOSING_LIMIT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                wcdc_pkg::REG_PERIOD_TICKS:
                    cfg_reg.period_ticks <= pwdata[wcdc_pkg::CFG_WIDTH-1:0];
                wcdc_pkg::REG_IDLE_LIMIT:
                    cfg_reg.idle_limit <= pwdata[wcdc_pkg::CFG_WIDTH-1:0];
                wcdc_pkg::REG_OPEN_LIMIT:
                    cfg_reg.open_limit <= pwdata[wcdc_pkg::CFG_WIDTH-1:0];
                wcdc_pkg::REG_CLOSING_LIMIT:
                    cfg_reg.closing_limit <= pwdata[wcdc_pkg::CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            wcdc_pkg::REG_PERIOD_TICKS:
                prdata = wcdc_pkg::APB_DATA_W'(cfg_reg.period_ticks);
            wcdc_pkg::REG_IDLE_LIMIT:
                prdata = wcdc_pkg::APB_DATA_W'(cfg_reg.idle_limit);
            wcdc_pkg::REG_OPEN_LIMIT:
                prdata = wcdc_pkg::APB_DATA_W'(cfg_reg.open_limit);
            wcdc_pkg::REG_CLOSING_LIMIT:
                prdata = wcdc_pkg::APB_DATA_W'(cfg_reg.closing_limit);
            default:
                prdata = '0;
        endcase
    end

endmodule

[src/wcdc_ctrl.sv]
// ----------------------------------------------------------------------------
// wcdc_ctrl
// prescaler, mode state machine, timeout counters and lamp state
// ----------------------------------------------------------------------------
module wcdc_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  wcdc_pkg::sense_t   sense,
    input  wcdc_pkg::cfg_t     cfg,
    output wcdc_pkg::result_t  result
);

    // compare width: wide enough for both counter and limit plus a carry
    localparam int CMP_W = ((COUNT_WIDTH > wcdc_pkg::CFG_WIDTH) ?
                            COUNT_WIDTH : wcdc_pkg::CFG_WIDTH) + 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    wcdc_pkg::mode_t         mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0]  prescale_reg, prescale_next;
    logic [COUNT_WIDTH-1:0]  idle_reg, idle_next;
    logic [COUNT_WIDTH-1:0]  open_reg, open_next;
    logic [COUNT_WIDTH-1:0]  closing_reg, closing_next;
    logic [1:0]              lamp_reg, lamp_next;

    logic [COUNT_WIDTH-1:0]  prescale_inc, idle_inc, open_inc, closing_inc;
    logic                    tick;
    logic                    do_enter;
    wcdc_pkg::mode_t         enter_mode;

    assign prescale_inc = (prescale_reg == CNT_MAX) ? prescale_reg : prescale_reg + CNT_ONE;
    assign idle_inc     = (idle_reg == CNT_MAX) ? idle_reg : idle_reg + CNT_ONE;
    assign open_inc     = (open_reg == CNT_MAX) ? open_reg : open_reg + CNT_ONE;
    assign closing_inc  = (closing_reg == CNT_MAX) ? closing_reg : closing_reg + CNT_ONE;

    // controller acts on the last tick of a period
    assign tick = (CMP_W'(prescale_reg) + CMP_W'(1)) >= CMP_W'(cfg.period_ticks);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= wcdc_pkg::MODE_ACCEPT;
            prescale_reg <= '0;
            idle_reg     <= '0;
            open_reg     <= '0;
            closing_reg  <= '0;
            lamp_reg     <= wcdc_pkg::LAMP_GREEN;
        end
        else
        begin
            mode_reg     <= mode_next;
            prescale_reg <= prescale_next;
            idle_reg     <= idle_next;
            open_reg     <= open_next;
            closing_reg  <= closing_next;
            lamp_reg     <= lamp_next;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        prescale_next = prescale_reg;
        idle_next     = idle_reg;
        open_next     = open_reg;
        closing_next  = closing_reg;
        lamp_next     = lamp_reg;
        do_enter      = 1'b0;
        enter_mode    = wcdc_pkg::MODE_ACCEPT;

        if (step)
        begin
            prescale_next = tick ? '0 : prescale_inc;
            if (tick)
            begin
                // rules in priority order; counters bump before their compare
                case (mode_reg)
                    wcdc_pkg::MODE_ACCEPT:
                    begin
                        idle_next = idle_inc;
                        do_enter  = 1'b1;
                        if (sense.temp_high)
                            enter_mode = wcdc_pkg::MODE_HOT;
                        else if (sense.level_full)
                            enter_mode = wcdc_pkg::MODE_FULL;
                        else if (sense.open_press)
                            enter_mode = wcdc_pkg::MODE_OPEN;
                        else if (CMP_W'(idle_inc) >= CMP_W'(cfg.idle_limit))
                            enter_mode = wcdc_pkg::MODE_IDLE_SLEEP;
                        else
                            do_enter = 1'b0;
                    end
                    wcdc_pkg::MODE_OPEN:
                    begin
                        open_next = open_inc;
                        do_enter  = 1'b1;
                        if (sense.temp_high)
                            enter_mode = wcdc_pkg::MODE_HOT;
                        else if (sense.level_full)
                            enter_mode = wcdc_pkg::MODE_FULL;
                        else if (sense.close_press ||
                                 CMP_W'(open_inc) >= CMP_W'(cfg.open_limit))
                            enter_mode = wcdc_pkg::MODE_CLOSING;
                        else
                            do_enter = 1'b0;
                    end
                    wcdc_pkg::MODE_CLOSING:
                    begin
                        closing_next = closing_inc;
                        do_enter     = 1'b1;
                        if (sense.temp_high)
                            enter_mode = wcdc_pkg::MODE_HOT;
                        else if (CMP_W'(closing_inc) >= CMP_W'(cfg.closing_limit))
                            enter_mode = wcdc_pkg::MODE_ACCEPT;
                        else
                            do_enter = 1'b0;
                    end
                    wcdc_pkg::MODE_IDLE_SLEEP:
                    begin
                        do_enter   = sense.user_present;
                        enter_mode = wcdc_pkg::MODE_ACCEPT;
                    end
                    wcdc_pkg::MODE_HOT:
                    begin
                        idle_next = idle_inc;
                        do_enter  = 1'b1;
                        if (CMP_W'(idle_inc) >= CMP_W'(cfg.idle_limit))
                            enter_mode = wcdc_pkg::MODE_FAULT_SLEEP;
                        else if (!sense.temp_high)
                            enter_mode = wcdc_pkg::MODE_ACCEPT;
                        else
                            do_enter = 1'b0;
                    end
                    wcdc_pkg::MODE_FULL:
                    begin
                        idle_next = idle_inc;
                        do_enter  = 1'b1;
                        if (CMP_W'(idle_inc) >= CMP_W'(cfg.idle_limit))
                            enter_mode = wcdc_pkg::MODE_FAULT_SLEEP;
                        else if (!sense.level_full)
                            enter_mode = wcdc_pkg::MODE_ACCEPT;
                        else
                            do_enter = 1'b0;
                    end
                    wcdc_pkg::MODE_FAULT_SLEEP:
                    begin
                        do_enter   = sense.user_present;
                        enter_mode = sense.level_full ? wcdc_pkg::MODE_FULL
                                                      : wcdc_pkg::MODE_HOT;
                    end
                    default:
                    begin
                        do_enter   = 1'b1;
                        enter_mode = wcdc_pkg::MODE_ACCEPT;
                    end
                endcase

                // entry actions override the counter bumps above
                if (do_enter)
                begin
                    mode_next = enter_mode;
                    case (enter_mode)
                        wcdc_pkg::MODE_ACCEPT:
                        begin
                            idle_next = '0;
                            lamp_next = wcdc_pkg::LAMP_GREEN;
                        end
                        wcdc_pkg::MODE_OPEN:
                            open_next = '0;
                        wcdc_pkg::MODE_CLOSING:
                            closing_next = '0;
                        wcdc_pkg::MODE_HOT, wcdc_pkg::MODE_FULL:
                        begin
                            idle_next = '0;
                            lamp_next = wcdc_pkg::LAMP_RED;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // result reflects the state after this tick
    always_comb
    begin
        result.mode_code    = mode_next;
        result.door_open    = (mode_next == wcdc_pkg::MODE_OPEN);
        result.green_on     = lamp_next[0];
        result.red_on       = lamp_next[1];
        result.message_code = wcdc_pkg::mode_message(mode_next);
    end

    // no state moves between transactions
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg) && $stable(prescale_reg) && $stable(idle_reg)
                  && $stable(lamp_reg))
        else $error("controller state changed without a transaction");

    // mode only changes on the last tick of a period
    a_mode_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        step && !tick |=> mode_reg == $past(mode_reg))
        else $error("mode changed off a period boundary");

    // idle sleep holds until a user shows up
    a_sleep_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && tick && mode_reg == wcdc_pkg::MODE_IDLE_SLEEP && !sense.user_present
        |=> mode_reg == wcdc_pkg::MODE_IDLE_SLEEP)
        else $error("idle sleep left without user presence");

    // entering accepting lights green only and clears the idle count
    a_accept_entry: assert property (@(posedge clk) disable iff (!rst_n)
        step && mode_reg != wcdc_pkg::MODE_ACCEPT && mode_next == wcdc_pkg::MODE_ACCEPT
        |=> lamp_reg == wcdc_pkg::LAMP_GREEN && idle_reg == '0)
        else $error("accepting entered without green lamp or idle reset");

endmodule

[src/waste_container_door_controller_core.sv]
// ----------------------------------------------------------------------------
// waste_container_door_controller_core
// door controller for a waste container, one scheduler tick per transaction
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     in_valid/in_ready   temp_high level_full open_press close_press
//                                user_present
//  output    out_valid/out_ready mode_code door_open green_on red_on
//                                message_code
//  config    apb psel/penable    period_ticks idle_limit open_limit
//                                closing_limit at 0x0/0x4/0x8/0xc
//
//  one transaction per cycle sustained while out_ready stays high; input
//  goes to the input register, then the state update loads the result register
//  asynchronous active-low reset puts the controller in accepting, green on
//  a stalled result register holds, and the input register keeps taking a
//  new tick whenever the result register is free or drains in the same cycle
// ----------------------------------------------------------------------------
module waste_container_door_controller_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // apb configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wcdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wcdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wcdc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // tick input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             temp_high,
    input  logic                             level_full,
    input  logic                             open_press,
    input  logic                             close_press,
    input  logic                             user_present,
    // result output
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       mode_code,
    output logic                             door_open,
    output logic                             green_on,
    output logic                             red_on,
    output logic [2:0]                       message_code
);

    wcdc_pkg::cfg_t     cfg;
    wcdc_pkg::sense_t   sense_reg;
    wcdc_pkg::result_t  result_comb;
    wcdc_pkg::result_t  result_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;

    // the held tick moves on when the result register is empty or draining
    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    wcdc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wcdc_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sense  (sense_reg),
        .cfg    (cfg),
        .result (result_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid & in_ready)
        begin
            sense_reg.temp_high    <= temp_high;
            sense_reg.level_full   <= level_full;
            sense_reg.open_press   <= open_press;
            sense_reg.close_press  <= close_press;
            sense_reg.user_present <= user_present;
        end
        if (advance)
            result_reg <= result_comb;
    end

    assign out_valid    = out_valid_reg;
    assign mode_code    = result_reg.mode_code;
    assign door_open    = result_reg.door_open;
    assign green_on     = result_reg.green_on;
    assign red_on       = result_reg.red_on;
    assign message_code = result_reg.message_code;

endmodule

[bench/wcdc_door_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wcdc_door_checker
// follows the register writes and both channels of the door controller,
// works out the expected mode, door, lamp and message for every tick and
// compares each result transaction against it in order
// ----------------------------------------------------------------------------
module wcdc_door_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        temp_high,
    input  logic        level_full,
    input  logic        open_press,
    input  logic        close_press,
    input  logic        user_present,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  mode_code,
    input  logic        door_open,
    input  logic        green_on,
    input  logic        red_on,
    input  logic [2:0]  message_code,
    output int          results_checked,
    output int          error_count,
    output logic [6:0]  modes_seen
);

    localparam int COUNT_W = 16;

    wcdc_pkg::cfg_t       cfg;
    logic [COUNT_W-1:0]   tick_count;
    logic [COUNT_W-1:0]   idle_periods;
    logic [COUNT_W-1:0]   open_periods;
    logic [COUNT_W-1:0]   closing_periods;
    wcdc_pkg::mode_t      mode;
    logic [1:0]           lamps;
    wcdc_pkg::result_t    pending_results [$];
    int                   mismatches;

    assign error_count = mismatches;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic void enter_mode(input wcdc_pkg::mode_t m);
        mode = m;
        case (m)
            wcdc_pkg::MODE_ACCEPT:
            begin
                idle_periods = '0;
                lamps        = wcdc_pkg::LAMP_GREEN;
            end
            wcdc_pkg::MODE_OPEN:    open_periods = '0;
            wcdc_pkg::MODE_CLOSING: closing_periods = '0;
            wcdc_pkg::MODE_HOT, wcdc_pkg::MODE_FULL:
            begin
                idle_periods = '0;
                lamps        = wcdc_pkg::LAMP_RED;
            end
            default: ;
        endcase
    endfunction

    // one controller period, rules in priority order
    function automatic void run_period(input wcdc_pkg::sense_t s);
        case (mode)
            wcdc_pkg::MODE_ACCEPT:
            begin
                idle_periods = bump(idle_periods);
                if (s.temp_high) enter_mode(wcdc_pkg::MODE_HOT);
                else if (s.level_full) enter_mode(wcdc_pkg::MODE_FULL);
                else if (s.open_press) enter_mode(wcdc_pkg::MODE_OPEN);
                else if (idle_periods >= cfg.idle_limit)
                    enter_mode(wcdc_pkg::MODE_IDLE_SLEEP);
            end
            wcdc_pkg::MODE_OPEN:
            begin
                open_periods = bump(open_periods);
                if (s.temp_high) enter_mode(wcdc_pkg::MODE_HOT);
                else if (s.level_full) enter_mode(wcdc_pkg::MODE_FULL);
                else if (s.close_press || open_periods >= cfg.open_limit)
                    enter_mode(wcdc_pkg::MODE_CLOSING);
            end
            wcdc_pkg::MODE_CLOSING:
            begin
                closing_periods = bump(closing_periods);
                if (s.temp_high) enter_mode(wcdc_pkg::MODE_HOT);
                else if (closing_periods >= cfg.closing_limit)
                    enter_mode(wcdc_pkg::MODE_ACCEPT);
            end
            wcdc_pkg::MODE_IDLE_SLEEP:
            begin
                if (s.user_present) enter_mode(wcdc_pkg::MODE_ACCEPT);
            end
            wcdc_pkg::MODE_HOT:
            begin
                idle_periods = bump(idle_periods);
                if (idle_periods >= cfg.idle_limit) enter_mode(wcdc_pkg::MODE_FAULT_SLEEP);
                else if (!s.temp_high) enter_mode(wcdc_pkg::MODE_ACCEPT);
            end
            wcdc_pkg::MODE_FULL:
            begin
                idle_periods = bump(idle_periods);
                if (idle_periods >= cfg.idle_limit) enter_mode(wcdc_pkg::MODE_FAULT_SLEEP);
                else if (!s.level_full) enter_mode(wcdc_pkg::MODE_ACCEPT);
            end
            wcdc_pkg::MODE_FAULT_SLEEP:
            begin
                if (s.user_present)
                    enter_mode(s.level_full ? wcdc_pkg::MODE_FULL : wcdc_pkg::MODE_HOT);
            end
            default: enter_mode(wcdc_pkg::MODE_ACCEPT);
        endcase
    endfunction

    function automatic wcdc_pkg::result_t predict_tick(input wcdc_pkg::sense_t s);
        wcdc_pkg::result_t r;
        wcdc_pkg::msg_t    msg;
        if ({1'b0, tick_count} + 1'b1 >= {1'b0, cfg.period_ticks})
        begin
            tick_count = '0;
            run_period(s);
        end
        else
        begin
            tick_count = bump(tick_count);
        end
        case (mode)
            wcdc_pkg::MODE_ACCEPT:  msg = wcdc_pkg::MSG_PRESS_OPEN;
            wcdc_pkg::MODE_OPEN:    msg = wcdc_pkg::MSG_PRESS_CLOSE;
            wcdc_pkg::MODE_CLOSING: msg = wcdc_pkg::MSG_RECEIVED;
            wcdc_pkg::MODE_HOT:     msg = wcdc_pkg::MSG_PROBLEM;
            wcdc_pkg::MODE_FULL:    msg = wcdc_pkg::MSG_FULL;
            default:                msg = wcdc_pkg::MSG_SCREEN_OFF;
        endcase
        r.mode_code    = mode;
        r.door_open    = (mode == wcdc_pkg::MODE_OPEN);
        r.green_on     = lamps[0];
        r.red_on       = lamps[1];
        r.message_code = msg;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t checker: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wcdc_pkg::sense_t  s;
        wcdc_pkg::result_t want;
        if (!rst_n)
        begin
            cfg.period_ticks  = wcdc_pkg::RST_PERIOD_TICKS;
            cfg.idle_limit    = wcdc_pkg::RST_IDLE_LIMIT;
            cfg.open_limit    = wcdc_pkg::RST_OPEN_LIMIT;
            cfg.closing_limit = wcdc_pkg::RST_CLOSING_LIMIT;
            tick_count        = '0;
            idle_periods      = '0;
            open_periods      = '0;
            closing_periods   = '0;
            mode              = wcdc_pkg::MODE_ACCEPT;
            lamps             = wcdc_pkg::LAMP_GREEN;
            pending_results.delete();
            mismatches        = 0;
            results_checked  <= 0;
            modes_seen       <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    wcdc_pkg::REG_PERIOD_TICKS:
                        cfg.period_ticks  = pwdata[wcdc_pkg::CFG_WIDTH-1:0];
                    wcdc_pkg::REG_IDLE_LIMIT:
                        cfg.idle_limit    = pwdata[wcdc_pkg::CFG_WIDTH-1:0];
                    wcdc_pkg::REG_OPEN_LIMIT:
                        cfg.open_limit    = pwdata[wcdc_pkg::CFG_WIDTH-1:0];
                    wcdc_pkg::REG_CLOSING_LIMIT:
                        cfg.closing_limit = pwdata[wcdc_pkg::CFG_WIDTH-1:0];
                    default: ;
                endcase
            end
            // result side first: a result can never belong to a tick taken this edge
            if (out_valid && out_ready)
            begin
                results_checked <= results_checked + 1;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t checker: result transaction with no tick pending, mode %0d",
                             $time, mode_code);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("mode_code", int'(want.mode_code), int'(mode_code));
                    check_field("door_open", int'(want.door_open), int'(door_open));
                    check_field("green_on", int'(want.green_on), int'(green_on));
                    check_field("red_on", int'(want.red_on), int'(red_on));
                    check_field("message_code", int'(want.message_code),
                                int'(message_code));
                end
            end
            if (in_valid && in_ready)
            begin
                s.temp_high    = temp_high;
                s.level_full   = level_full;
                s.open_press   = open_press;
                s.close_press  = close_press;
                s.user_present = user_present;
                pending_results.push_back(predict_tick(s));
                modes_seen <= modes_seen | (7'd1 << mode);
            end
        end
    end

endmodule

[bench/waste_container_door_controller_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waste_container_door_controller_core_test
// drives scripted and random sensor ticks through the door controller over a
// range of register settings, with random idling on both channels and one
// long output stall; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module waste_container_door_controller_core_test;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_TICKS     = 70;
    localparam int RANDOM_PHASES   = 12;
    localparam int HOLD_CYCLES     = 60;
    localparam int SCRIPT_LEN      = 25;
    localparam logic [16-1:0] CFG_MAX = 16'hffff;

    // bits per tick: temp_high level_full open_press close_press user_present
    localparam logic [5*SCRIPT_LEN-1:0] SCRIPT = {
        5'b00000, 5'b00100, 5'b00010, 5'b00000, 5'b00100,
        5'b00000, 5'b00000, 5'b10000, 5'b10000, 5'b10000,
        5'b11000, 5'b01001, 5'b00000, 5'b00000, 5'b00000,
        5'b11110, 5'b00001, 5'b11111, 5'b10000, 5'b00000,
        5'b10001, 5'b01110, 5'b01000, 5'b00000, 5'b00100
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        temp_high;
    logic        level_full;
    logic        open_press;
    logic        close_press;
    logic        user_present;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  mode_code;
    logic        door_open;
    logic        green_on;
    logic        red_on;
    logic [2:0]  message_code;

    int          results_checked;
    int          error_count;
    logic [6:0]  modes_seen;

    int          ticks_sent;
    int          settings_used;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count = 0;
    int          hold_left = 0;
    logic        hold_ask;
    logic        hold_seen = 1'b0;
    logic        hot_on;
    logic        full_on;

    waste_container_door_controller_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .temp_high    (temp_high),
        .level_full   (level_full),
        .open_press   (open_press),
        .close_press  (close_press),
        .user_present (user_present),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mode_code    (mode_code),
        .door_open    (door_open),
        .green_on     (green_on),
        .red_on       (red_on),
        .message_code (message_code)
    );

    wcdc_door_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .temp_high       (temp_high),
        .level_full      (level_full),
        .open_press      (open_press),
        .close_press     (close_press),
        .user_present    (user_present),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mode_code       (mode_code),
        .door_open       (door_open),
        .green_on        (green_on),
        .red_on          (red_on),
        .message_code    (message_code),
        .results_checked (results_checked),
        .error_count     (error_count),
        .modes_seen      (modes_seen)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        logic rdy;
        rdy = 1'b1;
        if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            rdy = 1'b0;
            hold_left--;
        end
        else if ($urandom_range(0, 99) < recv_idle_pct)
        begin
            rdy = 1'b0;
        end
        out_ready <= rdy;
    end

    task automatic send_tick(input wcdc_pkg::sense_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        temp_high    <= s.temp_high;
        level_full   <= s.level_full;
        open_press   <= s.open_press;
        close_press  <= s.close_press;
        user_present <= s.user_present;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers change only once every result is back
    task automatic set_config(input logic [15:0] period, input logic [15:0] idle,
                              input logic [15:0] open_lim, input logic [15:0] closing);
        in_valid <= 1'b0;
        while (results_checked != ticks_sent) @(posedge clk);
        write_reg(wcdc_pkg::REG_PERIOD_TICKS, period);
        write_reg(wcdc_pkg::REG_IDLE_LIMIT, idle);
        write_reg(wcdc_pkg::REG_OPEN_LIMIT, open_lim);
        write_reg(wcdc_pkg::REG_CLOSING_LIMIT, closing);
        settings_used++;
    endtask

    // faults stick for runs of ticks so the hot and full timeouts get reached
    function automatic wcdc_pkg::sense_t random_tick();
        wcdc_pkg::sense_t s;
        if ($urandom_range(0, 7) == 0)
        begin
            s = wcdc_pkg::sense_t'(5'($urandom_range(0, 31)));
        end
        else
        begin
            if ($urandom_range(0, 11) == 0) hot_on = ~hot_on;
            if ($urandom_range(0, 11) == 0) full_on = ~full_on;
            s.temp_high    = hot_on;
            s.level_full   = full_on;
            s.open_press   = ($urandom_range(0, 99) < 30);
            s.close_press  = ($urandom_range(0, 99) < 25);
            s.user_present = ($urandom_range(0, 99) < 30);
        end
        return s;
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        temp_high     = 1'b0;
        level_full    = 1'b0;
        open_press    = 1'b0;
        close_press   = 1'b0;
        user_present  = 1'b0;
        ticks_sent    = 0;
        settings_used = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_ask      = 1'b0;
        hot_on        = 1'b0;
        full_on       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scripted walk through every mode with short limits
        set_config(16'd1, 16'd2, 16'd2, 16'd1);
        for (int i = 0; i < SCRIPT_LEN; i++)
            send_tick(wcdc_pkg::sense_t'(SCRIPT[5*(SCRIPT_LEN-1-i) +: 5]));

        // zero period acts every tick, zero limits expire on the next period
        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 10; i++)
            send_tick(random_tick());

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph / 4)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 3)
                set_config(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
            else if (ph == 7)
                set_config(16'd1, 16'd1, 16'd1, 16'd1);
            else if (ph == 10)
                set_config(16'd1, CFG_MAX, CFG_MAX, CFG_MAX);
            else
                set_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)),
                           16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)));
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                // long output stall while ticks keep coming
                if (ph == 9 && i == 10)
                    hold_ask <= ~hold_ask;
                send_tick(random_tick());
            end
        end
        in_valid <= 1'b0;

        while (results_checked != ticks_sent) @(posedge clk);
        repeat (6) @(posedge clk);
        $display("tb: %0d ticks driven, %0d results checked across %0d register settings",
                 ticks_sent, results_checked, settings_used);
        $display("tb: modes reached %b, %0d mismatches", modes_seen, error_count);
        if (error_count == 0 && results_checked == ticks_sent)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[waste_container_door_controller_core.f]
src/wcdc_pkg.sv
src/wcdc_apb_regs.sv
src/wcdc_ctrl.sv
src/waste_container_door_controller_core.sv
bench/wcdc_door_checker.sv
bench/waste_container_door_controller_core_test.sv
